FILE: design/hrs_pkg.sv
// Shared types and constants of the heart-rate stabilizer.
`timescale 1ns / 1ps
package hrs_pkg;

	// Field widths
	localparam int RATE_W   = 12;
	localparam int CONF_W   = 4;
	localparam int CNT_W    = 8;
	localparam int WEIGHT_W = 9;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 12;
	localparam int TDATA_W  = 16;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_RATE_MIN       = 3'd0;
	localparam logic [IDX_W-1:0] REG_RATE_MAX       = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_STEP       = 3'd2;
	localparam logic [IDX_W-1:0] REG_CONFIRM_NEEDED = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOLD_LIMIT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_OLD_WEIGHT     = 3'd5;

	// Reset values of the registers
	localparam logic [RATE_W-1:0]   RST_RATE_MIN       = 12'd480;
	localparam logic [RATE_W-1:0]   RST_RATE_MAX       = 12'd3200;
	localparam logic [RATE_W-1:0]   RST_MAX_STEP       = 12'd80;
	localparam logic [CONF_W-1:0]   RST_CONFIRM_NEEDED = 4'd2;
	localparam logic [CNT_W-1:0]    RST_HOLD_LIMIT     = 8'd10;
	localparam logic [WEIGHT_W-1:0] RST_OLD_WEIGHT     = 9'd179;

	// Full-scale weight of the smoothing filter, Q1.8
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [CNT_W-1:0]    CNT_MAX    = 8'd255;

	typedef struct packed {
		logic [RATE_W-1:0]   rate_min;
		logic [RATE_W-1:0]   rate_max;
		logic [RATE_W-1:0]   max_step;
		logic [CONF_W-1:0]   confirm_needed;
		logic [CNT_W-1:0]    hold_limit;
		logic [WEIGHT_W-1:0] old_weight;
	} hrs_cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] prev_candidate;
		logic [RATE_W-1:0] smoothed_rate;
		logic [RATE_W-1:0] confirmed_rate;
		logic [CONF_W-1:0] agree_count;
		logic [CNT_W-1:0]  invalid_count;
		logic              have_candidate;
		logic              have_smoothed;
		logic              have_confirmed;
	} hrs_state_t;

endpackage

FILE: design/hrs_update.sv
// Per-window update of the stabilizer state and the output rate.
`timescale 1ns / 1ps
module hrs_update (
	input  hrs_pkg::hrs_cfg_t           cfg,
	input  hrs_pkg::hrs_state_t         st,
	input  logic [hrs_pkg::RATE_W-1:0]  rate,
	input  logic                        valid,
	output hrs_pkg::hrs_state_t         st_next,
	output logic [hrs_pkg::RATE_W-1:0]  rate_out
);
	import hrs_pkg::*;

	logic                is_cand;
	logic [RATE_W-1:0]   diff;
	logic                agrees;
	logic [CONF_W-1:0]   agree_next;
	logic [WEIGHT_W-1:0] w;
	logic [WEIGHT_W-1:0] w_new;
	logic [20:0]         prod_old;
	logic [20:0]         prod_new;
	logic [21:0]         acc;
	logic [RATE_W-1:0]   blended;

	// Candidate test and distance to the previous candidate.
	assign is_cand = valid && (rate >= cfg.rate_min) && (rate <= cfg.rate_max);
	assign diff    = (rate >= st.prev_candidate) ? (rate - st.prev_candidate)
	                                             : (st.prev_candidate - rate);
	assign agrees  = !st.have_candidate || (diff <= cfg.max_step);

	// Agreement count saturates at the required count; a jump restarts it at one.
	always_comb begin
		if (!agrees) begin
			agree_next = CONF_W'(1);
		end else if (st.agree_count < cfg.confirm_needed) begin
			agree_next = st.agree_count + CONF_W'(1);
		end else begin
			agree_next = st.agree_count;
		end
	end

	// Exponential average with round-half-up, weight clamped to one.
	assign w        = (cfg.old_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.old_weight;
	assign w_new    = WEIGHT_ONE - w;
	assign prod_old = 21'(w) * 21'(st.smoothed_rate);
	assign prod_new = 21'(w_new) * 21'(rate);
	assign acc      = 22'(prod_old) + 22'(prod_new) + 22'd128;
	assign blended  = acc[19:8];

	// Next state and result.
	always_comb begin
		st_next  = st;
		rate_out = '0;
		if (!is_cand) begin
			st_next.have_candidate = 1'b0;
			st_next.agree_count    = '0;
			if (st.invalid_count != CNT_MAX) begin
				st_next.invalid_count = st.invalid_count + CNT_W'(1);
			end
			if (st.have_confirmed && (st_next.invalid_count <= cfg.hold_limit)) begin
				rate_out = st.confirmed_rate;
			end
		end else begin
			st_next.invalid_count  = '0;
			st_next.agree_count    = agree_next;
			st_next.prev_candidate = rate;
			st_next.have_candidate = 1'b1;
			if (!agrees) begin
				st_next.have_smoothed = 1'b0;
			end
			if (agree_next < cfg.confirm_needed) begin
				rate_out = st.have_confirmed ? st.confirmed_rate : '0;
			end else begin
				if (!agrees || !st.have_smoothed) begin
					st_next.smoothed_rate = rate;
				end else begin
					st_next.smoothed_rate = blended;
				end
				st_next.have_smoothed  = 1'b1;
				st_next.confirmed_rate = st_next.smoothed_rate;
				st_next.have_confirmed = 1'b1;
				rate_out               = st_next.smoothed_rate;
			end
		end
	end

endmodule

FILE: design/heart_rate_stabilizer_unit.sv
// Top level of the heart-rate stabilizer: stream ports, registers, state.
// Path: an accepted transaction waits in the input register and is loaded into the result
//   register once that register is free; the result register then presents its result.
// Throughput: one estimate per cycle; the input register stalls only while it is full
//   and the result register holds a transaction that the receiver does not take.
// Reset: arst_n clears the stabilizer state and valid flags and restores the register defaults; no clear pass.
`timescale 1ns / 1ps
module heart_rate_stabilizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hrs_pkg::TDATA_W-1:0]  s_tdata,   // [11:0] rate_in, [15:12] zero
	input  logic                         s_tuser,   // [0] rate_valid
	// Output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hrs_pkg::TDATA_W-1:0]  m_tdata,   // [11:0] rate_out, [15:12] zero
	// Configuration writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hrs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [hrs_pkg::DATA_W-1:0]   cfg_data
);
	import hrs_pkg::*;

	hrs_cfg_t          cfg_q;
	hrs_state_t        st_q;
	hrs_state_t        st_next;
	logic              in_valid_s1;
	logic [RATE_W-1:0] rate_s1;
	logic              flag_s1;
	logic              out_valid_q;
	logic [RATE_W-1:0] rate_out_q;
	logic [RATE_W-1:0] rate_calc;
	logic              advance;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_min       <= RST_RATE_MIN;
			cfg_q.rate_max       <= RST_RATE_MAX;
			cfg_q.max_step       <= RST_MAX_STEP;
			cfg_q.confirm_needed <= RST_CONFIRM_NEEDED;
			cfg_q.hold_limit     <= RST_HOLD_LIMIT;
			cfg_q.old_weight     <= RST_OLD_WEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RATE_MIN:       cfg_q.rate_min       <= cfg_data;
				REG_RATE_MAX:       cfg_q.rate_max       <= cfg_data;
				REG_MAX_STEP:       cfg_q.max_step       <= cfg_data;
				REG_CONFIRM_NEEDED: cfg_q.confirm_needed <= cfg_data[CONF_W-1:0];
				REG_HOLD_LIMIT:     cfg_q.hold_limit     <= cfg_data[CNT_W-1:0];
				REG_OLD_WEIGHT:     cfg_q.old_weight     <= cfg_data[WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline control: the input stage moves on when the result register is free.
	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rate_s1 <= s_tdata[RATE_W-1:0];
			flag_s1 <= s_tuser;
		end
	end

	// Update logic for one window.
	hrs_update u_update (
		.cfg      (cfg_q),
		.st       (st_q),
		.rate     (rate_s1),
		.valid    (flag_s1),
		.st_next  (st_next),
		.rate_out (rate_calc)
	);

	// Stabilizer state advances with each transaction leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rate_out_q <= rate_calc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-RATE_W){1'b0}}, rate_out_q};

	// A nonzero rate can only come from a confirmed average.
	a_nonzero_confirmed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (rate_out_q != '0)) |-> st_q.have_confirmed)
		else $error("nonzero rate without a confirmed average");

	// An average exists only after a confirmation.
	a_smoothed_confirmed: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.have_smoothed |-> st_q.have_confirmed)
		else $error("average present without confirmation");

	// Invalid windows and a live candidate exclude each other.
	a_invalid_no_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.invalid_count != '0) |-> !st_q.have_candidate)
		else $error("candidate kept across invalid windows");

	// Every window leaving the input stage fills the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	// A stalled input stage keeps its window.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(rate_s1)))
		else $error("stalled window lost");

endmodule

FILE: bench/tb_heart_rate_stabilizer_unit.sv
// Self-checking testbench of the heart-rate stabilizer with its own prediction of each output.
`timescale 1ns / 1ps
module tb_heart_rate_stabilizer_unit;
	import hrs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_WINDOWS = 120;
	localparam int PHASE_COUNT   = 10;
	localparam int OPENING_ROWS  = 21;
	localparam int HOLD_OFF      = 64;
	localparam int SETTLE        = 4;

	// One row of the opening table: estimate, flag, and an optional fixed output.
	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              ok;
		logic              pinned;
		logic [RATE_W-1:0] want;
	} window_row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [DATA_W-1:0]   cfg_data = '0;

	// Predicted register contents and tracking state.
	hrs_cfg_t            regs;
	hrs_state_t          track;
	logic [RATE_W-1:0]   expected_rates [$];
	window_row_t         opening_rows [0:OPENING_ROWS-1];

	int unsigned         errors = 0;
	int unsigned         cycle_count = 0;
	int unsigned         hold_requests = 0;
	int unsigned         hold_served = 0;
	int unsigned         hold_left = 0;
	logic                steady = 1'b0;

	heart_rate_stabilizer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Guard against a hung handshake.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("heart_rate_stabilizer_unit test failed");
		$finish;
	end

	task automatic log_error(input string msg);
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	// Apply one register write to the predicted settings.
	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		case (idx)
			REG_RATE_MIN:       regs.rate_min = val[RATE_W-1:0];
			REG_RATE_MAX:       regs.rate_max = val[RATE_W-1:0];
			REG_MAX_STEP:       regs.max_step = val[RATE_W-1:0];
			REG_CONFIRM_NEEDED: regs.confirm_needed = val[CONF_W-1:0];
			REG_HOLD_LIMIT:     regs.hold_limit = val[CNT_W-1:0];
			REG_OLD_WEIGHT:     regs.old_weight = val[WEIGHT_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the tracking state by one window and return the stabilized rate.
	function automatic logic [RATE_W-1:0] next_stable_rate(input logic [RATE_W-1:0] rate,
			input logic ok);
		logic [RATE_W-1:0]   diff;
		logic [WEIGHT_W-1:0] w;
		logic [21:0]         acc;
		// Rejected window: drop the candidate, count it, hold or blank the output.
		if (!ok || rate < regs.rate_min || rate > regs.rate_max) begin
			track.have_candidate = 1'b0;
			track.agree_count = '0;
			if (track.invalid_count != CNT_MAX)
				track.invalid_count = track.invalid_count + 1'b1;
			return (track.have_confirmed && track.invalid_count <= regs.hold_limit) ?
				track.confirmed_rate : '0;
		end
		track.invalid_count = '0;
		// Agreement with the previous candidate builds confirmation; a jump restarts it.
		diff = (rate >= track.prev_candidate) ? rate - track.prev_candidate :
			track.prev_candidate - rate;
		if (!track.have_candidate || diff <= regs.max_step) begin
			if (track.agree_count < regs.confirm_needed)
				track.agree_count = track.agree_count + 1'b1;
		end else begin
			track.agree_count = CONF_W'(1);
			track.have_smoothed = 1'b0;
		end
		track.prev_candidate = rate;
		track.have_candidate = 1'b1;
		if (track.agree_count < regs.confirm_needed)
			return track.have_confirmed ? track.confirmed_rate : '0;
		// Confirmed: load the average or blend the new candidate into it.
		if (!track.have_smoothed) begin
			track.smoothed_rate = rate;
			track.have_smoothed = 1'b1;
		end else begin
			w = (regs.old_weight > WEIGHT_ONE) ? WEIGHT_ONE : regs.old_weight;
			acc = w * track.smoothed_rate + (WEIGHT_ONE - w) * rate + 22'd128;
			track.smoothed_rate = acc[19:8];
		end
		track.confirmed_rate = track.smoothed_rate;
		track.have_confirmed = 1'b1;
		return track.confirmed_rate;
	endfunction

	// Offer one window, with random gaps unless steady, and record its expected output once accepted.
	task automatic send_window(input logic [RATE_W-1:0] rate, input logic ok,
			input logic pinned, input logic [RATE_W-1:0] want);
		logic [RATE_W-1:0] predicted;
		if (!steady) begin
			while ($urandom_range(99) < 21) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_W'(rate);
		s_tuser <= ok;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = next_stable_rate(rate, ok);
		expected_rates.push_back(pinned ? want : predicted);
	endtask

	// Stop offering and let every outstanding result drain.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_rates.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all six registers back to back while the block is idle.
	task automatic load_settings(input hrs_cfg_t next);
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		int                k;
		wait_quiet();
		for (k = 0; k < 6; k++) begin
			case (k)
				0: begin idx = REG_RATE_MIN;       val = DATA_W'(next.rate_min);       end
				1: begin idx = REG_RATE_MAX;       val = DATA_W'(next.rate_max);       end
				2: begin idx = REG_MAX_STEP;       val = DATA_W'(next.max_step);       end
				3: begin idx = REG_CONFIRM_NEEDED; val = DATA_W'(next.confirm_needed); end
				4: begin idx = REG_HOLD_LIMIT;     val = DATA_W'(next.hold_limit);     end
				default: begin idx = REG_OLD_WEIGHT; val = DATA_W'(next.old_weight); end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_reg(idx, val);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random windows: mostly drifting runs of candidates, with jumps, rejected bursts and noise.
	task automatic run_windows(input int count);
		int sent;
		int lo;
		int hi;
		int span;
		int d;
		int walk;
		int burst;
		int pick;
		sent = 0;
		burst = 0;
		lo = int'(regs.rate_min);
		hi = int'(regs.rate_max);
		span = int'(regs.max_step) + 2;
		if (span > 600)
			span = 600;
		walk = (lo <= hi) ? int'($urandom_range(hi, lo)) : 0;
		while (sent < count || burst > 0) begin
			pick = int'($urandom_range(99));
			if (burst > 0) begin
				burst--;
				send_window(RATE_W'($urandom_range(4095)), 1'b0, 1'b0, '0);
			end else if (lo > hi || pick >= 86) begin
				send_window(RATE_W'($urandom_range(4095)), 1'($urandom_range(1)), 1'b0, '0);
			end else if (pick < 70) begin
				d = int'($urandom_range(2 * span)) - span;
				walk = walk + d;
				if (walk < lo)
					walk = lo;
				if (walk > hi)
					walk = hi;
				send_window(RATE_W'(walk), 1'b1, 1'b0, '0);
			end else if (pick < 80) begin
				case ($urandom_range(3))
					0: walk = lo;
					1: walk = hi;
					default: walk = int'($urandom_range(hi, lo));
				endcase
				send_window(RATE_W'(walk), 1'b1, 1'b0, '0);
			end else begin
				// Rejected burst, often just past the hold limit.
				burst = ($urandom_range(1) == 1) ?
					int'(regs.hold_limit) + int'($urandom_range(3, 1)) :
					int'($urandom_range(int'(regs.hold_limit) + 3));
				send_window(RATE_W'($urandom_range(4095)), 1'b0, 1'b0, '0);
			end
			sent++;
		end
	endtask

	// Output side: check each transaction, then choose the next ready value.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rates.size() == 0) begin
				log_error($sformatf("unexpected output rate %0d", m_tdata[RATE_W-1:0]));
			end else if (m_tdata[RATE_W-1:0] != expected_rates[0]) begin
				log_error($sformatf("rate_out %0d, expected %0d", m_tdata[RATE_W-1:0],
					expected_rates[0]));
				void'(expected_rates.pop_front());
			end else begin
				void'(expected_rates.pop_front());
			end
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_OFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 21);
		end
	end

	// Main sequence: reset, opening table, then phases under several settings.
	initial begin
		hrs_cfg_t next;
		int       p;
		int       r;
		regs.rate_min = RST_RATE_MIN;
		regs.rate_max = RST_RATE_MAX;
		regs.max_step = RST_MAX_STEP;
		regs.confirm_needed = RST_CONFIRM_NEEDED;
		regs.hold_limit = RST_HOLD_LIMIT;
		regs.old_weight = RST_OLD_WEIGHT;
		track = '0;
		// Reset settings: window lo/hi 480..3200, step 80, two to confirm, hold 10.
		opening_rows = '{
			'{12'd1000, 1'b0, 1'b1, 12'd0},     // flagged invalid, nothing confirmed yet
			'{12'd1000, 1'b1, 1'b1, 12'd0},     // first candidate, not yet confirmed
			'{12'd1040, 1'b1, 1'b1, 12'd1040},  // confirmed, average loaded directly
			'{12'd1060, 1'b1, 1'b0, 12'd0},     // first blended value
			'{12'd4095, 1'b1, 1'b0, 12'd0},     // largest estimate, above range
			'{12'd0,    1'b1, 1'b0, 12'd0},     // zero estimate, below range
			'{12'd480,  1'b1, 1'b0, 12'd0},     // exactly at the lower bound
			'{12'd3200, 1'b1, 1'b0, 12'd0},     // jump to the upper bound
			'{12'd3200, 1'b1, 1'b1, 12'd3200},  // confirmed again after the jump
			'{12'd3120, 1'b1, 1'b0, 12'd0},     // change of exactly max_step
			'{12'd3201, 1'b1, 1'b0, 12'd0},     // one above the range
			'{12'd479,  1'b1, 1'b0, 12'd0},     // one below the range
			'{12'hAAA,  1'b0, 1'b0, 12'd0},
			'{12'h555,  1'b0, 1'b0, 12'd0},
			'{12'hAAA,  1'b0, 1'b0, 12'd0},
			'{12'h555,  1'b0, 1'b0, 12'd0},
			'{12'hAAA,  1'b0, 1'b0, 12'd0},
			'{12'h555,  1'b0, 1'b0, 12'd0},
			'{12'hAAA,  1'b0, 1'b0, 12'd0},
			'{12'h555,  1'b0, 1'b0, 12'd0},     // tenth rejected window, still held
			'{12'hFFF,  1'b0, 1'b1, 12'd0}      // past the hold limit, output blanked
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < OPENING_ROWS; r++)
			send_window(opening_rows[r].rate, opening_rows[r].ok, opening_rows[r].pinned,
				opening_rows[r].want);

		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: next = '{RST_RATE_MIN, RST_RATE_MAX, RST_MAX_STEP, RST_CONFIRM_NEEDED,
					RST_HOLD_LIMIT, RST_OLD_WEIGHT};
				// Widest range, zero step, no hold, new value taken whole.
				1: next = '{12'd0, 12'd4095, 12'd0, 4'd1, 8'd0, 9'd0};
				// Single-point range, longest confirmation and hold, average frozen.
				2: next = '{12'd4095, 12'd4095, 12'd4095, 4'd15, 8'd255, 9'd256};
				// Inverted bounds and a weight above full scale.
				3: next = '{12'd3000, 12'd1000, 12'd100, 4'd3, 8'd5, 9'd300};
				// Zero confirmation requirement, zero rate allowed, largest weight code.
				4: next = '{12'd0, 12'd200, 12'd50, 4'd0, 8'd3, 9'd511};
				5: next = '{12'd300, 12'd2500, 12'd30, 4'd4, 8'd40, 9'd200};
				default: begin
					next.rate_min = RATE_W'($urandom_range(2000));
					next.rate_max = RATE_W'($urandom_range(4095, next.rate_min));
					next.max_step = RATE_W'($urandom_range(400));
					next.confirm_needed = CONF_W'($urandom_range(15));
					next.hold_limit = CNT_W'($urandom_range(20));
					next.old_weight = ($urandom_range(3) == 0) ?
						WEIGHT_W'($urandom_range(511)) : WEIGHT_W'($urandom_range(256));
				end
			endcase
			load_settings(next);
			steady = (p == 2);
			// Stall the output long enough to back up the input side.
			if (p == 0)
				hold_requests++;
			run_windows(PHASE_WINDOWS);
		end
		steady = 1'b0;

		wait_quiet();
		if (errors == 0)
			$display("heart_rate_stabilizer_unit test passed");
		else
			$display("heart_rate_stabilizer_unit test failed");
		$finish;
	end

endmodule
